// File: sv/assert_macros.svh
// Assertion helpers shared by the RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked check that is held off while reset is asserted.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK_RST(label, clk, rst, prop, msg)
`define ASSERT_CLK(label, clk, prop, msg)

`endif

`endif

// File: sv/mctt_pkg.sv
package mctt_pkg;

  // Command codes carried in the kind field.
  localparam logic [2:0] KIND_TICK      = 3'd0;
  localparam logic [2:0] KIND_SET       = 3'd1;
  localparam logic [2:0] KIND_SET_COUNT = 3'd2;
  localparam logic [2:0] KIND_START     = 3'd3;
  localparam logic [2:0] KIND_STOP      = 3'd4;
  localparam logic [2:0] KIND_RESET     = 3'd5;
  localparam logic [2:0] KIND_ALLOC     = 3'd6;

  // Width of the reported expiry mask.
  localparam int unsigned MASK_W = 8;

  // One command transfer.
  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  timer_index;
    logic [31:0] value;
    logic        one_shot;
  } cmd_t;

  // One result transfer.
  typedef struct packed {
    logic [MASK_W-1:0] expired_mask;
    logic [3:0]        handle;
    logic              handle_valid;
    logic [31:0]       tick_total;
  } res_t;

  // Command broadcast from the controller to every timer cell.
  typedef struct packed {
    logic go;
    cmd_t cmd;
  } cell_req_t;

endpackage

// File: sv/mctt_cell.sv
module mctt_cell
  import mctt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_req_t req,
  input  logic      sel,
  input  logic      alloc_prev,
  output logic      alloc,
  output logic      expire
);

  logic        enabled;
  logic [31:0] count;
  logic [31:0] reload;
  logic        oneshot;

  logic        enabled_next;
  logic [31:0] count_next;
  logic [31:0] reload_next;
  logic        oneshot_next;
  logic        alloc_next;
  logic [31:0] count_dec;

  assign count_dec = count - 32'd1;

  // Next state of this timer for the command being accepted.
  always_comb begin
    enabled_next = enabled;
    count_next   = count;
    reload_next  = reload;
    oneshot_next = oneshot;
    alloc_next   = alloc;
    expire       = 1'b0;
    if (req.go) begin
      case (req.cmd.kind)
        KIND_TICK: begin
          if (alloc && enabled) begin
            count_next = count_dec;
            if (count_dec == 32'd0) begin
              count_next = reload;
              expire     = 1'b1;
              if (oneshot) begin
                enabled_next = 1'b0;
              end
            end
          end
        end
        KIND_SET: begin
          if (sel) begin
            oneshot_next = req.cmd.one_shot;
            count_next   = req.cmd.value;
            reload_next  = req.cmd.value;
          end
        end
        KIND_SET_COUNT: begin
          if (sel) begin
            count_next = req.cmd.value;
          end
        end
        KIND_START: begin
          if (sel) begin
            enabled_next = 1'b1;
          end
        end
        KIND_STOP: begin
          if (sel) begin
            enabled_next = 1'b0;
          end
        end
        KIND_RESET: begin
          if (sel) begin
            enabled_next = 1'b0;
            count_next   = reload;
          end
        end
        KIND_ALLOC: begin
          // The handle goes to the first free cell along the row.
          if (alloc_prev && !alloc) begin
            alloc_next = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Timer state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b0;
      count   <= '0;
      reload  <= '0;
      oneshot <= 1'b0;
      alloc   <= 1'b0;
    end else begin
      enabled <= enabled_next;
      count   <= count_next;
      reload  <= reload_next;
      oneshot <= oneshot_next;
      alloc   <= alloc_next;
    end
  end

endmodule

// File: sv/multi_channel_tick_timer_bank.sv
// Bank of TIMERS down-counting timers, each held in a cell of a row that
// updates all timers in parallel. One command is taken per cycle and its
// result appears in the output register on the next cycle, so the block
// sustains one command per clock while res_stall is low; the result
// register is the only stage and a held result stalls the command side.
// Handles are handed out along the row: a cell takes the next allocation
// when its left neighbour is already allocated. Only the first eight
// timers are reported in expired_mask; handle is the allocation count
// truncated to four bits.
`include "assert_macros.svh"

module multi_channel_tick_timer_bank
  import mctt_pkg::*;
#(
  parameter int unsigned TIMERS = 8
)
(
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  cmd_t cmd,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  localparam int unsigned CW = $clog2(TIMERS + 1);

  logic              accept;
  cell_req_t         req;
  logic [TIMERS-1:0] sel;
  logic [TIMERS-1:0] alloc_vec;
  logic [TIMERS-1:0] alloc_chain;
  logic [TIMERS-1:0] expire_vec;
  logic [MASK_W-1:0] mask;
  logic [CW-1:0]     alloc_count;
  logic [CW-1:0]     alloc_count_next;
  logic [31:0]       tick_count;
  logic [31:0]       tick_count_next;
  logic              alloc_free;
  res_t              res_next;

  // Handshake: a command is taken whenever the result register can move.
  assign cmd_stall = res_valid && res_stall;
  assign accept    = cmd_valid && !cmd_stall;
  assign req.go    = accept;
  assign req.cmd   = cmd;

  // The row of timer cells, with the allocation flag passed along it.
  assign alloc_chain[0] = 1'b1;

  for (genvar i = 0; i < TIMERS; i++) begin : g_cell
    assign sel[i] = (7'(cmd.timer_index) == 7'(i));

    mctt_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .req        (req),
      .sel        (sel[i]),
      .alloc_prev (alloc_chain[i]),
      .alloc      (alloc_vec[i]),
      .expire     (expire_vec[i])
    );

    if (i + 1 < TIMERS) begin : g_link
      assign alloc_chain[i+1] = alloc_vec[i];
    end
  end

  // Expiry mask covers the first eight timers.
  for (genvar b = 0; b < MASK_W; b++) begin : g_mask
    if (b < TIMERS) begin : g_live
      assign mask[b] = expire_vec[b];
    end else begin : g_none
      assign mask[b] = 1'b0;
    end
  end

  // Tick and allocation counters, and the result of this command.
  assign alloc_free = (alloc_count != CW'(TIMERS));

  always_comb begin
    tick_count_next  = tick_count;
    alloc_count_next = alloc_count;
    res_next         = '0;
    case (cmd.kind)
      KIND_TICK: begin
        tick_count_next       = tick_count + 32'd1;
        res_next.expired_mask = mask;
      end
      KIND_ALLOC: begin
        res_next.handle = 4'(alloc_count);
        if (alloc_free) begin
          res_next.handle_valid = 1'b1;
          alloc_count_next      = alloc_count + CW'(1);
        end
      end
      default: begin
      end
    endcase
    res_next.tick_total = tick_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count  <= '0;
      alloc_count <= '0;
    end else if (accept) begin
      tick_count  <= tick_count_next;
      alloc_count <= alloc_count_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  // Checks on the allocation row and the counters.
  logic [TIMERS-1:0] alloc_left;
  assign alloc_left = TIMERS'({alloc_vec, 1'b1});

  `ASSERT_CLK_RST(a_alloc_count, clk, rst, $countones(alloc_vec) == alloc_count, "allocation count and cells disagree")
  `ASSERT_CLK_RST(a_alloc_row, clk, rst, (alloc_vec & ~alloc_left) == '0, "allocated cells are not a prefix of the row")
  `ASSERT_CLK_RST(a_tick_inc, clk, rst, accept && cmd.kind == KIND_TICK |=> tick_count == $past(tick_count) + 32'd1, "tick counter did not advance")
  `ASSERT_CLK_RST(a_handle_kind, clk, rst, accept && cmd.kind != KIND_ALLOC |=> res_valid && !res.handle_valid, "handle reported for a command other than allocate")

endmodule
